### design/pftr_pkg.sv
// pftr_pkg: shared types, format codes and q14 constants for the pixel format converter
// no dependencies; used by pftr_pixel_conv and pixel_format_to_rgb888
package pftr_pkg;

    // source format codes held in the configuration register
    typedef enum logic [1:0] {
        FMT_RGBA8 = 2'd0,
        FMT_GRAY8 = 2'd1,
        FMT_YUYV  = 2'd2,
        FMT_BW    = 2'd3
    } t_src_fmt;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [7:0] byte_d;
    } t_in_beat;

    // one output pixel beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_item;
    } t_out_beat;

    // fixed-point widths for the yuv sums
    localparam int QShift  = 14;
    localparam int SumW    = 25;

    // q14 colour coefficients
    localparam logic [15:0] CoefR  = 16'd22970;
    localparam logic [15:0] CoefGu = 16'd5636;
    localparam logic [15:0] CoefGv = 16'd11698;
    localparam logic [15:0] CoefB  = 16'd29032;

    localparam logic [8:0] ChromaOffset = 9'd128;
    localparam logic [7:0] ChanMax      = 8'd255;

    // clamp a signed q14 sum to a byte: negative gives 0, overflow gives 255
    function automatic logic [7:0] q14_to_byte(input logic signed [SumW-1:0] sum);
        logic [7:0] res;
        if (sum[SumW-1]) begin
            res = 8'd0;
        end else if (|sum[SumW-2:QShift+8]) begin
            res = ChanMax;
        end else begin
            res = sum[QShift+7:QShift];
        end
        return res;
    endfunction

endpackage

### design/pftr_pixel_conv.sv
// pftr_pixel_conv: combinational conversion of one held beat into one rgb pixel
// depends on pftr_pkg (beat types, format codes, q14 constants)
module pftr_pixel_conv (
    input  pftr_pkg::t_src_fmt  i_fmt,
    input  pftr_pkg::t_in_beat  i_beat,
    input  logic                i_second,
    output pftr_pkg::t_out_beat o_pixel
);

    logic        [7:0]               w_y;
    logic signed [8:0]               w_u;
    logic signed [8:0]               w_v;
    logic signed [pftr_pkg::SumW-1:0] w_u_ext;
    logic signed [pftr_pkg::SumW-1:0] w_v_ext;
    logic signed [pftr_pkg::SumW-1:0] w_s;
    logic signed [pftr_pkg::SumW-1:0] w_sum_r;
    logic signed [pftr_pkg::SumW-1:0] w_sum_g;
    logic signed [pftr_pkg::SumW-1:0] w_sum_b;
    logic        [7:0]               w_bw;

    // luma picks Y1 on the first pixel and Y2 on the second
    assign w_y = i_second ? i_beat.byte_c : i_beat.byte_a;

    // centred chroma
    assign w_u = $signed({1'b0, i_beat.byte_b} - pftr_pkg::ChromaOffset);
    assign w_v = $signed({1'b0, i_beat.byte_d} - pftr_pkg::ChromaOffset);
    assign w_u_ext = pftr_pkg::SumW'(w_u);
    assign w_v_ext = pftr_pkg::SumW'(w_v);

    // q14 sums, constant multipliers only
    assign w_s     = $signed({{(pftr_pkg::SumW - 8 - pftr_pkg::QShift){1'b0}}, w_y,
                              {pftr_pkg::QShift{1'b0}}});
    assign w_sum_r = w_s + w_v_ext * $signed(pftr_pkg::SumW'(pftr_pkg::CoefR));
    assign w_sum_g = w_s - w_u_ext * $signed(pftr_pkg::SumW'(pftr_pkg::CoefGu))
                         - w_v_ext * $signed(pftr_pkg::SumW'(pftr_pkg::CoefGv));
    assign w_sum_b = w_s + w_u_ext * $signed(pftr_pkg::SumW'(pftr_pkg::CoefB));

    assign w_bw = (i_beat.byte_a != 8'd0) ? pftr_pkg::ChanMax : 8'd0;

    // format select
    always_comb begin
        o_pixel.last_of_item = 1'b1;
        unique case (i_fmt)
            pftr_pkg::FMT_RGBA8: begin
                o_pixel.red   = i_beat.byte_a;
                o_pixel.green = i_beat.byte_b;
                o_pixel.blue  = i_beat.byte_c;
            end
            pftr_pkg::FMT_GRAY8: begin
                o_pixel.red   = i_beat.byte_a;
                o_pixel.green = i_beat.byte_a;
                o_pixel.blue  = i_beat.byte_a;
            end
            pftr_pkg::FMT_YUYV: begin
                o_pixel.red          = pftr_pkg::q14_to_byte(w_sum_r);
                o_pixel.green        = pftr_pkg::q14_to_byte(w_sum_g);
                o_pixel.blue         = pftr_pkg::q14_to_byte(w_sum_b);
                o_pixel.last_of_item = i_second;
            end
            default: begin
                o_pixel.red   = w_bw;
                o_pixel.green = w_bw;
                o_pixel.blue  = w_bw;
            end
        endcase
    end

endmodule

### design/pixel_format_to_rgb888.sv
// pixel_format_to_rgb888: top level, input register, format register and pixel output register
// depends on pftr_pkg and pftr_pixel_conv
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall | o_out_beat (t_out_beat)
//  cfg     | input     | i_cfg_wr_en             | i_cfg_wr_data (source format)
//
// a beat enters the input register, is converted and lands in the output register;
// the second yuyv pixel of a beat follows the first from the same held input beat.
// one pixel leaves per cycle through the single output register while the output is not
// stalled; RGBA8, GRAY8 and BW then take one item per cycle, YUYV one item per two pixels.
// synchronous active-low reset clears the valid flags and sets the format to RGBA8.
// a stall on the output holds the output register and, once the input register is
// full, stalls the input.
module pixel_format_to_rgb888 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pftr_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pftr_pkg::t_out_beat o_out_beat
);

    pftr_pkg::t_src_fmt  r_source_format;
    logic                r_in_valid;
    pftr_pkg::t_in_beat  r_in_beat;
    logic                r_half;
    logic                r_out_valid;
    pftr_pkg::t_out_beat r_out_beat;

    pftr_pkg::t_out_beat w_pixel;
    logic                w_out_free;
    logic                w_emit;
    logic                w_item_done;
    logic                w_in_take;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= pftr_pkg::FMT_RGBA8;
        end else if (i_cfg_wr_en) begin
            r_source_format <= pftr_pkg::t_src_fmt'(i_cfg_wr_data);
        end
    end

    // handshake control
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = r_in_valid && w_out_free;
    assign w_item_done = !((r_source_format == pftr_pkg::FMT_YUYV) && !r_half);
    assign o_in_stall  = r_in_valid && !(w_emit && w_item_done);
    assign w_in_take   = i_in_valid && !o_in_stall;

    // input register and yuyv second-pixel flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_half     <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_emit && w_item_done) begin
                r_in_valid <= 1'b0;
            end
            if (w_emit) begin
                r_half <= !w_item_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    pftr_pixel_conv u_conv (
        .i_fmt    (r_source_format),
        .i_beat   (r_in_beat),
        .i_second (r_half),
        .o_pixel  (w_pixel)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_beat <= w_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // second-pixel flag only while a beat is held
    a_half_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_in_valid)
        else $error("second pixel pending without a held beat");

    // a non-final pixel only comes from a yuyv pair
    a_first_only_yuyv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.last_of_item) |-> (r_source_format == pftr_pkg::FMT_YUYV))
        else $error("non-final pixel outside yuyv format");

    // an accepted beat is held in the next cycle
    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted beat lost");

endmodule

### bench/pixel_convert_checker.sv
// pixel_convert_checker: watches the config, input and output channels of the converter,
// predicts every output pixel and compares it field by field with what comes out
// depends on pftr_pkg for the beat structs and format codes
`timescale 1ns / 1ps

module pixel_convert_checker
    import pftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_beat   i_in_beat,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_beat  i_out_beat,
    output int         o_fail_count,
    output int         o_pending
);

    // q14 colour conversion constants
    localparam int QBits      = 14;
    localparam int CoefRed    = 22970;
    localparam int CoefGreenU = 5636;
    localparam int CoefGreenV = 11698;
    localparam int CoefBlue   = 29032;
    localparam int ChromaMid  = 128;
    localparam int ReportMax  = 10;

    t_src_fmt  fmt_copy = FMT_RGBA8;
    t_out_beat pixels_due[$];
    t_out_beat want;
    int        fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // negative sums clip to black, large ones saturate at white
    function automatic logic [7:0] clamp_q14(input int sum);
        int shifted;
        if (sum < 0) begin
            return 8'd0;
        end
        shifted = sum >>> QBits;
        if (shifted > 255) begin
            return 8'd255;
        end
        return shifted[7:0];
    endfunction

    function automatic t_out_beat make_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic last);
        t_out_beat px;
        px.red          = r;
        px.green        = g;
        px.blue         = b;
        px.last_of_item = last;
        return px;
    endfunction

    function automatic t_out_beat yuv_pixel(input int luma, input int u, input int v,
                                            input logic last);
        int base;
        base = luma * (1 << QBits);
        return make_pixel(clamp_q14(base + CoefRed * v),
                          clamp_q14(base - CoefGreenU * u - CoefGreenV * v),
                          clamp_q14(base + CoefBlue * u), last);
    endfunction

    // queue the pixels one source beat turns into under the current format
    task automatic queue_pixels(input t_in_beat src);
        int u;
        int v;
        case (fmt_copy)
            FMT_RGBA8: begin
                pixels_due.push_back(make_pixel(src.byte_a, src.byte_b, src.byte_c, 1'b1));
            end
            FMT_GRAY8: begin
                pixels_due.push_back(make_pixel(src.byte_a, src.byte_a, src.byte_a, 1'b1));
            end
            FMT_YUYV: begin
                u = int'(src.byte_b) - ChromaMid;
                v = int'(src.byte_d) - ChromaMid;
                pixels_due.push_back(yuv_pixel(int'(src.byte_a), u, v, 1'b0));
                pixels_due.push_back(yuv_pixel(int'(src.byte_c), u, v, 1'b1));
            end
            default: begin
                if (src.byte_a != 8'd0) begin
                    pixels_due.push_back(make_pixel(8'hff, 8'hff, 8'hff, 1'b1));
                end else begin
                    pixels_due.push_back(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
                end
            end
        endcase
    endtask

    // sample every channel at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_copy = FMT_RGBA8;
            pixels_due.delete();
        end else begin
            // output beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ReportMax) begin
                        $display("%0t: pixel with none expected: r=%0d g=%0d b=%0d last=%0d",
                                 $realtime, i_out_beat.red, i_out_beat.green,
                                 i_out_beat.blue, i_out_beat.last_of_item);
                    end
                end else begin
                    want = pixels_due.pop_front();
                    if (i_out_beat.red !== want.red || i_out_beat.green !== want.green ||
                        i_out_beat.blue !== want.blue ||
                        i_out_beat.last_of_item !== want.last_of_item) begin
                        fail_count++;
                        if (fail_count <= ReportMax) begin
                            $display({"%0t: pixel mismatch: expected r=%0d g=%0d b=%0d ",
                                      "last=%0d, got r=%0d g=%0d b=%0d last=%0d"},
                                     $realtime, want.red, want.green, want.blue,
                                     want.last_of_item, i_out_beat.red, i_out_beat.green,
                                     i_out_beat.blue, i_out_beat.last_of_item);
                        end
                    end
                end
            end
            // accepted source beat
            if (i_in_valid && !i_in_stall) begin
                queue_pixels(i_in_beat);
            end
            // format register write
            if (i_cfg_wr_en) begin
                fmt_copy = t_src_fmt'(i_cfg_wr_data);
            end
        end
        o_pending    = pixels_due.size();
        o_fail_count = fail_count;
    end

endmodule

### bench/testbench.sv
// testbench: drives directed and random source pixels through pixel_format_to_rgb888
// under every source format, with random input gaps and output stalls; depends on
// pftr_pkg, the design and pixel_convert_checker, which does the prediction and comparison
`timescale 1ns / 1ps

module testbench;
    import pftr_pkg::*;

    localparam int ClkPeriod  = 12;
    localparam int CycleLimit = 1_000_000;
    localparam int PhaseCount = 8;
    localparam int PhaseBeats = 250;
    localparam int BlockBeats = 50;

    logic      clk;
    logic      rst_n;
    logic      cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        stall_left  = 0;
    logic      calm        = 1'b0;
    t_src_fmt  phase_fmt;

    pixel_format_to_rgb888 DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_beat    (out_beat)
    );

    pixel_convert_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_beat    (out_beat),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // output stall pattern, changed at the falling edge
    always @(negedge clk) begin
        if (stall_left == 0) begin
            if (calm || $urandom_range(0, 2) != 0) begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(1, 8);
            end else begin
                out_stall  <= 1'b1;
                stall_left = pause_len();
            end
        end
        stall_left--;
    end

    // offer one source beat and hold it until accepted; valid stays up back to back
    task automatic send_pixel(input t_in_beat src);
        int gap;
        gap = (calm || $urandom_range(0, 3) != 0) ? 0 : pause_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_beat  = src;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait until every predicted pixel has come out
    task automatic drain_pixels();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_format(input t_src_fmt fmt);
        drain_pixels();
        cfg_wr_data = fmt;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // random source beat, biased towards the corners that matter for each format
    function automatic t_in_beat random_pixel(input t_src_fmt fmt);
        t_in_beat src;
        src = t_in_beat'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            src.byte_a = $urandom_range(0, 1) ? 8'hff : 8'h00;
            src.byte_c = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        if (fmt == FMT_BW && $urandom_range(0, 3) == 0) begin
            src.byte_a = 8'h00;
        end
        if (fmt == FMT_YUYV && $urandom_range(0, 7) == 0) begin
            src.byte_b = $urandom_range(0, 1) ? 8'h80 : ($urandom_range(0, 1) ? 8'hff : 8'h00);
            src.byte_d = $urandom_range(0, 1) ? 8'h80 : ($urandom_range(0, 1) ? 8'hff : 8'h00);
        end
        return src;
    endfunction

    // stimulus and verdict
    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = FMT_RGBA8;
        in_valid    = 1'b0;
        in_beat     = '0;
        out_stall   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // rgba8 from the reset value, alpha ignored
        send_pixel(32'h00000000);
        send_pixel(32'hffffffff);
        send_pixel(32'h12345678);
        send_pixel(32'ha55aa55a);

        // gray copied to all channels, other bytes ignored
        set_format(FMT_GRAY8);
        send_pixel(32'h00ffffff);
        send_pixel(32'hff000000);
        send_pixel(32'h80808080);

        // black and white: a nonzero first byte gives white, the other bytes are ignored
        set_format(FMT_BW);
        send_pixel(32'h00ffffff);
        send_pixel(32'h01000000);
        send_pixel(32'h80000000);
        send_pixel(32'hff000000);

        // yuyv: negative sums, saturation, neutral chroma, truncation
        set_format(FMT_YUYV);
        send_pixel(32'h00000000);
        send_pixel(32'hffffffff);
        send_pixel(32'h00ff00ff);
        send_pixel(32'hff00ff00);
        send_pixel(32'h1080eb80);
        send_pixel(32'h00800080);
        send_pixel(32'h64327f90);

        // random phases: every format first, then random ones
        for (int phase = 0; phase < PhaseCount; phase++) begin
            if (phase < 4) begin
                phase_fmt = t_src_fmt'(phase);
            end else begin
                phase_fmt = t_src_fmt'($urandom_range(0, 3));
            end
            set_format(phase_fmt);
            for (int n = 0; n < PhaseBeats; n++) begin
                if (n % BlockBeats == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                // sender holds off until the pipeline is empty now and then
                if ($urandom_range(0, 99) == 0) begin
                    drain_pixels();
                end
                send_pixel(random_pixel(phase_fmt));
            end
        end

        drain_pixels();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
